FILE: src/pat3d_pkg.sv
`default_nettype none

package pat3d_pkg;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int WEIGHT_W = 18;
    localparam int ROW_W    = 3 * WEIGHT_W;
    localparam int PROD_W   = COORD_W + WEIGHT_W;
    localparam int ACC_W    = 54;
    localparam int FRAC_W   = 16;
    localparam int QUOT_W   = ACC_W - FRAC_W;
    localparam int LANES    = 3;
    localparam int IDX_W    = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_COEF_X   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_Y   = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_Z   = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_OFFSET_Z = 3'd5;

    // Reset rows: identity matrix
    localparam logic [ROW_W-1:0] COEF_X_RST = 54'h0_0000_0001_0000;
    localparam logic [ROW_W-1:0] COEF_Y_RST = 54'h0_0004_0000_0000;
    localparam logic [ROW_W-1:0] COEF_Z_RST = 54'h10_0000_0000_0000;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = 54'sd32768;

    // Load strobes for the lane pipeline registers
    typedef struct packed {
        logic load_prod;
        logic load_acc;
    } lane_ctl_t;

endpackage

`default_nettype wire

FILE: src/point_affine_transform_3d.sv
`default_nettype none

// Affine transform of 3D points: each request carries one point (x, y, z in
// signed Q16.16) and yields one point equal to a configured 3x3 matrix of
// signed Q2.16 weights times the input, plus a configured Q16.16 translation,
// rounded to nearest (ties up) and saturated to 32 bits; tuser flags any
// clamped component. One point is accepted every cycle unless the output stalls;
// each point passes through three lanes, one per output component, each
// with its own three 18x32 multipliers, then an adder stage, then the merge
// output register. Write configuration only while no point is in flight.
module point_affine_transform_3d (
    input  wire                                             aclk,
    input  wire                                             aresetn,
    // configuration write port
    input  wire                                             cfg_wr_en,
    input  wire  [pat3d_pkg::IDX_W-1:0]                     cfg_index,
    input  wire  [pat3d_pkg::ROW_W-1:0]                     cfg_wdata,
    // input points
    input  wire                                             s_tvalid,
    output logic                                            s_tready,
    input  wire  [pat3d_pkg::LANES*pat3d_pkg::COORD_W-1:0]  s_tdata,  // in_x, in_y, in_z
    // transformed points
    output logic                                            m_tvalid,
    input  wire                                             m_tready,
    output logic [pat3d_pkg::LANES*pat3d_pkg::COORD_W-1:0]  m_tdata,  // out_x, out_y, out_z
    output logic                                            m_tuser   // saturated
);

    localparam int CW = pat3d_pkg::COORD_W;
    localparam int RW = pat3d_pkg::ROW_W;
    localparam int NL = pat3d_pkg::LANES;

    logic [NL-1:0][RW-1:0]     coef_reg;
    logic [NL-1:0][CW-1:0]     offset_reg;
    logic                      prod_valid_reg, acc_valid_reg;
    logic                      prod_ready, acc_ready, merge_ready;
    pat3d_pkg::lane_ctl_t      ctl;
    logic [NL-1:0][CW-1:0]     lane_value;
    logic [NL-1:0]             lane_sat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0]   <= pat3d_pkg::COEF_X_RST;
            coef_reg[1]   <= pat3d_pkg::COEF_Y_RST;
            coef_reg[2]   <= pat3d_pkg::COEF_Z_RST;
            offset_reg[0] <= '0;
            offset_reg[1] <= '0;
            offset_reg[2] <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pat3d_pkg::REG_COEF_X:   coef_reg[0]   <= cfg_wdata;
                pat3d_pkg::REG_COEF_Y:   coef_reg[1]   <= cfg_wdata;
                pat3d_pkg::REG_COEF_Z:   coef_reg[2]   <= cfg_wdata;
                pat3d_pkg::REG_OFFSET_X: offset_reg[0] <= cfg_wdata[CW-1:0];
                pat3d_pkg::REG_OFFSET_Y: offset_reg[1] <= cfg_wdata[CW-1:0];
                pat3d_pkg::REG_OFFSET_Z: offset_reg[2] <= cfg_wdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // Ripple ready back through the stages so bubbles are squeezed out
    assign acc_ready  = !acc_valid_reg || merge_ready;
    assign prod_ready = !prod_valid_reg || acc_ready;
    assign s_tready   = prod_ready;

    assign ctl.load_prod = prod_ready;
    assign ctl.load_acc  = acc_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            acc_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= s_tvalid;
            end
            if (acc_ready) begin
                acc_valid_reg <= prod_valid_reg;
            end
        end
    end

    // One lane per output component
    for (genvar i = 0; i < NL; i++) begin : g_lane
        pat3d_lane u_lane (
            .aclk     (aclk),
            .ctl      (ctl),
            .coef_row (coef_reg[i]),
            .offset   (offset_reg[i]),
            .in_x     (s_tdata[CW-1:0]),
            .in_y     (s_tdata[2*CW-1:CW]),
            .in_z     (s_tdata[3*CW-1:2*CW]),
            .value    (lane_value[i]),
            .sat      (lane_sat[i])
        );
    end

    pat3d_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (acc_valid_reg),
        .in_ready   (merge_ready),
        .lane_value (lane_value),
        .lane_sat   (lane_sat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

FILE: src/pat3d_lane.sv
`default_nettype none

module pat3d_lane (
    input  wire                                      aclk,
    input  wire  pat3d_pkg::lane_ctl_t               ctl,
    input  wire  [pat3d_pkg::ROW_W-1:0]              coef_row,
    input  wire  signed [pat3d_pkg::COORD_W-1:0]     offset,
    input  wire  signed [pat3d_pkg::COORD_W-1:0]     in_x,
    input  wire  signed [pat3d_pkg::COORD_W-1:0]     in_y,
    input  wire  signed [pat3d_pkg::COORD_W-1:0]     in_z,
    output logic signed [pat3d_pkg::COORD_W-1:0]     value,
    output logic                                     sat
);

    localparam int WW = pat3d_pkg::WEIGHT_W;
    localparam int PW = pat3d_pkg::PROD_W;
    localparam int AW = pat3d_pkg::ACC_W;
    localparam int CW = pat3d_pkg::COORD_W;
    localparam int FW = pat3d_pkg::FRAC_W;
    localparam int QW = pat3d_pkg::QUOT_W;

    logic signed [WW-1:0] w_x, w_y, w_z;
    logic signed [PW-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [PW-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [AW-1:0] acc_next, acc_reg;
    logic signed [QW-1:0] quot;

    // Split the row into its three weights
    assign w_x = coef_row[WW-1:0];
    assign w_y = coef_row[2*WW-1:WW];
    assign w_z = coef_row[3*WW-1:2*WW];

    // Stage one: one multiplier per weight
    always_comb begin
        prod_x_next = w_x * in_x;
        prod_y_next = w_y * in_y;
        prod_z_next = w_z * in_z;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
        end
    end

    // Stage two: exact sum with the shifted offset and the rounding half
    always_comb begin
        acc_next = {{(AW-PW){prod_x_reg[PW-1]}}, prod_x_reg}
                 + {{(AW-PW){prod_y_reg[PW-1]}}, prod_y_reg}
                 + {{(AW-PW){prod_z_reg[PW-1]}}, prod_z_reg}
                 + {{(AW-CW-FW){offset[CW-1]}}, offset, {FW{1'b0}}}
                 + pat3d_pkg::ROUND_HALF;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_acc) begin
            acc_reg <= acc_next;
        end
    end

    // Floor to whole Q16.16 units, then clamp to 32 bits
    assign quot = acc_reg[AW-1:FW];

    always_comb begin
        sat   = (quot[QW-1:CW-1] != {(QW-CW+1){1'b0}})
             && (quot[QW-1:CW-1] != {(QW-CW+1){1'b1}});
        value = quot[CW-1:0];
        if (sat) begin
            value = quot[QW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

FILE: src/pat3d_merge.sv
`default_nettype none

module pat3d_merge (
    input  wire                                                   aclk,
    input  wire                                                   aresetn,
    input  wire                                                   in_valid,
    output logic                                                  in_ready,
    input  wire  [pat3d_pkg::LANES-1:0][pat3d_pkg::COORD_W-1:0]   lane_value,
    input  wire  [pat3d_pkg::LANES-1:0]                           lane_sat,
    output logic                                                  m_tvalid,
    input  wire                                                   m_tready,
    output logic [pat3d_pkg::LANES*pat3d_pkg::COORD_W-1:0]        m_tdata,
    output logic                                                  m_tuser
);

    logic                                                  valid_reg;
    logic [pat3d_pkg::LANES*pat3d_pkg::COORD_W-1:0]        data_reg;
    logic                                                  sat_reg;

    // Take a new request when the output slot is empty or being drained
    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Pack lanes x, y, z from the low bits up; any clamped lane flags the point
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= lane_value;
            sat_reg  <= |lane_sat;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = sat_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb_point_affine_transform_3d.sv
`timescale 1ns / 100ps

module tb_point_affine_transform_3d;

    // Indexes past the last register; writes there must leave every register alone
    localparam logic [pat3d_pkg::IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [pat3d_pkg::IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN = 32'h8000_0000;
    localparam logic [31:0] C_ONE = 32'h0001_0000;
    localparam logic [31:0] C_NEG = 32'hFFFF_FFFF;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 12;
    localparam int PHASE_POINTS  = 107;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        sat;
    } point_result_t;

    logic                                             aclk = 1'b0;
    logic                                             aresetn = 1'b0;
    logic                                             cfg_wr_en = 1'b0;
    logic [pat3d_pkg::IDX_W-1:0]                      cfg_index = '0;
    logic [pat3d_pkg::ROW_W-1:0]                      cfg_wdata = '0;
    logic                                             s_tvalid = 1'b0;
    logic                                             s_tready;
    logic [pat3d_pkg::LANES*pat3d_pkg::COORD_W-1:0]   s_tdata = '0;   // in_x, in_y, in_z
    logic                                             m_tvalid;
    logic                                             m_tready = 1'b0;
    logic [pat3d_pkg::LANES*pat3d_pkg::COORD_W-1:0]   m_tdata;        // out_x, out_y, out_z
    logic                                             m_tuser;        // saturated

    // Shadow copy of the transform registers
    logic [pat3d_pkg::ROW_W-1:0]  coef_row [pat3d_pkg::LANES];
    logic [31:0]                  offset_reg [pat3d_pkg::LANES];

    point_result_t                expected_points [$];
    int                           mismatch_count = 0;
    int                           cycle_count = 0;
    bit                           no_idle = 1'b0;

    point_affine_transform_3d dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // One output lane: dot product plus shifted offset, round half up, clamp
    function automatic logic [32:0] transform_lane(
            input logic [pat3d_pkg::ROW_W-1:0] row,
            input logic [31:0] offs,
            input logic [pat3d_pkg::LANES*pat3d_pkg::COORD_W-1:0] pt);
        logic signed [63:0] acc;
        logic signed [63:0] w;
        logic signed [63:0] c;
        logic signed [63:0] q;
        logic               clamped;
        int                 k;
        acc = {{16{offs[31]}}, offs, 16'h0000};
        for (k = 0; k < pat3d_pkg::LANES; k++) begin
            w   = {{46{row[pat3d_pkg::WEIGHT_W*k+pat3d_pkg::WEIGHT_W-1]}},
                   row[pat3d_pkg::WEIGHT_W*k +: pat3d_pkg::WEIGHT_W]};
            c   = {{32{pt[pat3d_pkg::COORD_W*k+pat3d_pkg::COORD_W-1]}},
                   pt[pat3d_pkg::COORD_W*k +: pat3d_pkg::COORD_W]};
            acc = acc + w * c;
        end
        acc     = acc + 64'sd32768;
        q       = acc >>> pat3d_pkg::FRAC_W;
        clamped = 1'b0;
        if (q > Q_MAX) begin
            q       = Q_MAX;
            clamped = 1'b1;
        end else if (q < Q_MIN) begin
            q       = Q_MIN;
            clamped = 1'b1;
        end
        return {clamped, q[31:0]};
    endfunction

    function automatic point_result_t transform_point(
            input logic [pat3d_pkg::LANES*pat3d_pkg::COORD_W-1:0] pt);
        logic [32:0]   lx;
        logic [32:0]   ly;
        logic [32:0]   lz;
        point_result_t r;
        lx    = transform_lane(coef_row[0], offset_reg[0], pt);
        ly    = transform_lane(coef_row[1], offset_reg[1], pt);
        lz    = transform_lane(coef_row[2], offset_reg[2], pt);
        r.x   = lx[31:0];
        r.y   = ly[31:0];
        r.z   = lz[31:0];
        r.sat = lx[32] | ly[32] | lz[32];
        return r;
    endfunction

    function automatic logic [pat3d_pkg::ROW_W-1:0] pack_row(input logic [17:0] wx,
                                                             input logic [17:0] wy,
                                                             input logic [17:0] wz);
        return {wz, wy, wx};
    endfunction

    function automatic logic [31:0] random_coord();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: v = C_MAX;
                    1: v = C_MIN;
                    2: v = 32'h0;
                    3: v = C_NEG;
                    default: v = C_ONE;
                endcase
            end
            1, 2, 3: v = $urandom;
            default: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] random_weight();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            6, 7: v = $urandom;
            8, 9: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h2_0000;
                    1: v = 32'h1_FFFF;
                    2: v = 32'h0;
                    3: v = 32'h1_0000;
                    default: v = 32'h3_0000;
                endcase
            end
            default: v = $urandom_range(0, 32'h2_0000) - 32'h1_0000;
        endcase
        return v[17:0];
    endfunction

    // Offset word with random bits above the register width
    function automatic logic [pat3d_pkg::ROW_W-1:0] random_offset();
        logic [31:0] lo;
        logic [31:0] hi;
        hi = $urandom;
        if ($urandom_range(0, 1) == 0) lo = $urandom;
        else                           lo = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        return {hi[21:0], lo};
    endfunction

    // Drive one write and mirror it; the caller lowers the enable afterward
    task automatic write_reg(input logic [pat3d_pkg::IDX_W-1:0] idx,
                             input logic [pat3d_pkg::ROW_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            pat3d_pkg::REG_COEF_X:   coef_row[0]   = val;
            pat3d_pkg::REG_COEF_Y:   coef_row[1]   = val;
            pat3d_pkg::REG_COEF_Z:   coef_row[2]   = val;
            pat3d_pkg::REG_OFFSET_X: offset_reg[0] = val[31:0];
            pat3d_pkg::REG_OFFSET_Y: offset_reg[1] = val[31:0];
            pat3d_pkg::REG_OFFSET_Z: offset_reg[2] = val[31:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic load_transform(input logic [pat3d_pkg::ROW_W-1:0] rx,
                                  input logic [pat3d_pkg::ROW_W-1:0] ry,
                                  input logic [pat3d_pkg::ROW_W-1:0] rz,
                                  input logic [pat3d_pkg::ROW_W-1:0] ox,
                                  input logic [pat3d_pkg::ROW_W-1:0] oy,
                                  input logic [pat3d_pkg::ROW_W-1:0] oz);
        write_reg(pat3d_pkg::REG_COEF_X, rx);
        write_reg(pat3d_pkg::REG_COEF_Y, ry);
        write_reg(pat3d_pkg::REG_COEF_Z, rz);
        write_reg(pat3d_pkg::REG_OFFSET_X, ox);
        write_reg(pat3d_pkg::REG_OFFSET_Y, oy);
        write_reg(pat3d_pkg::REG_OFFSET_Z, oz);
        cfg_wr_en <= 1'b0;
    endtask

    // Present one point request, hold it until accepted
    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        expected_points.push_back(transform_point({pz, py, px}));
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off requests until every result is back and the pipeline has drained
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random stall before each result
    initial begin : drain_results
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge aclk) begin : check_result
        point_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected result: out_x %0d out_y %0d out_z %0d",
                       $signed(m_tdata[31:0]), $signed(m_tdata[63:32]),
                       $signed(m_tdata[95:64]));
                mismatch_count++;
            end else begin
                want = expected_points.pop_front();
                if (m_tdata[31:0] !== want.x) begin
                    $error("out_x: expected %0d, actual %0d",
                           $signed(want.x), $signed(m_tdata[31:0]));
                    mismatch_count++;
                end
                if (m_tdata[63:32] !== want.y) begin
                    $error("out_y: expected %0d, actual %0d",
                           $signed(want.y), $signed(m_tdata[63:32]));
                    mismatch_count++;
                end
                if (m_tdata[95:64] !== want.z) begin
                    $error("out_z: expected %0d, actual %0d",
                           $signed(want.z), $signed(m_tdata[95:64]));
                    mismatch_count++;
                end
                if (m_tuser !== want.sat) begin
                    $error("saturated: expected %0d, actual %0d", want.sat, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Identity transform straight out of reset
    task automatic test_reset_identity();
        send_point(32'h0, 32'h0, 32'h0);
        send_point(C_MAX, C_MIN, C_NEG);
        send_point(C_MIN, C_MAX, C_ONE);
        send_point(C_ONE, 32'hFFFF_0000, C_MAX);
        wait_idle();
    endtask

    // Half-LSB ties round up, below half rounds down, both signs
    task automatic test_rounding();
        load_transform(pack_row(18'h0_8000, 18'h0, 18'h0),
                       pack_row(18'h0, 18'h3_8000, 18'h0),
                       pack_row(18'h0, 18'h0, 18'h0_4000),
                       '0, '0, '0);
        send_point(32'h1, 32'h1, 32'h1);
        send_point(C_NEG, C_NEG, C_NEG);
        send_point(32'h3, 32'h3, 32'h2);
        send_point(32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'hFFFF_FFFE);
        wait_idle();
    endtask

    // Clamp at both bounds; -2.0 weight pattern and largest positive weight
    task automatic test_saturation();
        load_transform(pack_row(18'h1_FFFF, 18'h1_FFFF, 18'h1_FFFF),
                       pack_row(18'h2_0000, 18'h2_0000, 18'h2_0000),
                       pack_row(18'h2_0000, 18'h0, 18'h0),
                       {22'h0, C_MAX}, {22'h0, C_MIN}, {22'h0, C_ONE});
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h0000_8000, 32'h0, 32'h0);
        send_point(C_MIN, C_MAX, 32'h0);
        wait_idle();
    endtask

    // Translation only; spare indexes ignored; offset bits past 32 dropped
    task automatic test_register_edges();
        write_reg(pat3d_pkg::REG_COEF_X, pat3d_pkg::COEF_X_RST);
        write_reg(pat3d_pkg::REG_COEF_Y, pat3d_pkg::COEF_Y_RST);
        write_reg(pat3d_pkg::REG_COEF_Z, pat3d_pkg::COEF_Z_RST);
        write_reg(pat3d_pkg::REG_OFFSET_X, {22'h3F_FFFF, 32'h0001_8000});
        write_reg(pat3d_pkg::REG_OFFSET_Y, {22'h2A_AAAA, 32'hFFFE_0000});
        write_reg(pat3d_pkg::REG_OFFSET_Z, {22'h15_5555, C_MAX});
        write_reg(REG_SPARE_A, random_offset());
        write_reg(REG_SPARE_B, random_offset());
        cfg_wr_en <= 1'b0;
        send_point(32'h0, 32'h0, 32'h0);
        send_point(C_MAX, C_MIN, C_ONE);
        send_point(C_NEG, 32'h0002_0000, 32'h0);
        wait_idle();
    endtask

    // Random transforms, extremes first, with mid-phase pauses and bursts
    task automatic test_random_transforms();
        logic [pat3d_pkg::ROW_W-1:0] rows [pat3d_pkg::LANES];
        int               phase;
        int               n;
        int               k;
        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            if (phase == 0) begin
                for (k = 0; k < pat3d_pkg::LANES; k++)
                    rows[k] = pack_row(18'h1_FFFF, 18'h1_FFFF, 18'h1_FFFF);
                load_transform(rows[0], rows[1], rows[2],
                               {22'h3F_FFFF, C_MAX}, {22'h0, C_MIN}, {22'h0, C_MAX});
            end else if (phase == 1) begin
                for (k = 0; k < pat3d_pkg::LANES; k++)
                    rows[k] = pack_row(18'h2_0000, 18'h2_0000, 18'h2_0000);
                load_transform(rows[0], rows[1], rows[2],
                               {22'h0, C_MIN}, {22'h3F_FFFF, C_MAX}, {22'h0, C_MIN});
            end else begin
                for (k = 0; k < pat3d_pkg::LANES; k++)
                    rows[k] = pack_row(random_weight(), random_weight(), random_weight());
                if (phase % 3 == 0) write_reg(phase % 2 ? REG_SPARE_A : REG_SPARE_B,
                                              random_offset());
                load_transform(rows[0], rows[1], rows[2],
                               random_offset(), random_offset(), random_offset());
            end
            for (n = 0; n < PHASE_POINTS; n++) begin
                if (n % 20 == 0) no_idle = (phase == 5) || ($urandom_range(0, 3) == 0);
                if (n == PHASE_POINTS / 2 && phase % 4 == 2) wait_idle();
                send_point(random_coord(), random_coord(), random_coord());
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        coef_row[0]   = pat3d_pkg::COEF_X_RST;
        coef_row[1]   = pat3d_pkg::COEF_Y_RST;
        coef_row[2]   = pat3d_pkg::COEF_Z_RST;
        offset_reg[0] = '0;
        offset_reg[1] = '0;
        offset_reg[2] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_identity();
        test_rounding();
        test_saturation();
        test_register_edges();
        test_random_transforms();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
